// ----- design/cmac_pkg.sv -----
// ----------------------------------------------------------------------------
// cmac_pkg
// shared types and constants of the covariance matrix accumulator
// ----------------------------------------------------------------------------
package cmac_pkg;

    localparam int MAX_COLUMNS = 8;
    localparam int COL_W       = 3;
    localparam int CFG_W       = 4;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int SUM_W       = 48;
    localparam int COV_W       = 32;
    localparam int DIVD_W      = SUM_W + 1;
    localparam int MAX_ROWS    = 65536;

    localparam logic [CFG_W-1:0] COLS_MIN   = CFG_W'(2);
    localparam logic [CFG_W-1:0] COLS_MAX   = CFG_W'(MAX_COLUMNS);
    localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(8);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_set;
    } t_in;

    typedef struct packed {
        logic [COL_W-1:0]        row_index;
        logic [COL_W-1:0]        col_index;
        logic signed [COV_W-1:0] covariance;
        logic                    too_few_rows;
        logic                    last_entry;
    } t_out;

    // sample travelling down the cell chain
    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic [COL_W-1:0]           col;
        logic signed [SAMPLE_W-1:0] x;
    } t_tok;

endpackage

// ----- design/cmac_cell.sv -----
// ----------------------------------------------------------------------------
// cmac_cell
// one chain cell: holds one row sample and the sums of its matrix row
// ----------------------------------------------------------------------------
module cmac_cell #(
    parameter logic [cmac_pkg::COL_W-1:0] CELL_IDX = '0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  cmac_pkg::t_tok              i_tok,
    output cmac_pkg::t_tok              o_tok,
    input  logic [cmac_pkg::COL_W-1:0]  i_rd_col,
    output logic [cmac_pkg::SUM_W-1:0]  o_rd_data
);
    import cmac_pkg::*;

    logic signed [SAMPLE_W-1:0] r_rb;
    logic signed [PROD_W-1:0]   r_prod;
    t_tok                       r_tok;
    logic signed [SUM_W-1:0]    r_acc [MAX_COLUMNS];

    logic signed [SAMPLE_W-1:0] w_mul_a;
    logic signed [SUM_W:0]      w_sum;
    logic signed [SUM_W-1:0]    w_sat;

    // own column uses the fresh sample
    assign w_mul_a = (i_tok.col == CELL_IDX) ? i_tok.x : r_rb;

    always_comb begin
        w_sum = {r_acc[r_tok.col][SUM_W-1], r_acc[r_tok.col]}
              + (SUM_W+1)'(r_prod);
        if (w_sum[SUM_W] != w_sum[SUM_W-1]) begin
            w_sat = w_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid && i_tok.col == CELL_IDX) begin
            r_rb <= i_tok.x;
        end
        r_prod <= w_mul_a * i_tok.x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int k = 0; k < MAX_COLUMNS; k++) begin
                r_acc[k] <= '0;
            end
        end else if (r_tok.valid && r_tok.col >= CELL_IDX) begin
            r_acc[r_tok.col] <= w_sat;
        end
    end

    assign o_tok     = r_tok;
    assign o_rd_data = r_acc[i_rd_col];

endmodule

// ----- design/cmac_div.sv -----
// ----------------------------------------------------------------------------
// cmac_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cmac_div #(
    parameter int ROW_W = 17
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cmac_pkg::DIVD_W-1:0]  i_num,
    input  logic [ROW_W-1:0]             i_den,
    output logic                         o_done,
    output logic [cmac_pkg::DIVD_W-1:0]  o_quo
);
    import cmac_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_quo;
    logic [ROW_W-1:0]  r_rem;
    logic [ROW_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROW_W:0]    w_try;
    logic [ROW_W:0]    w_diff;
    logic              w_ge;

    assign w_try  = {r_rem, r_quo[DIVD_W-1]};
    assign w_diff = w_try - {1'b0, r_den};
    assign w_ge   = (w_try >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[ROW_W-1:0] : w_try[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- design/covariance_matrix_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// covariance_matrix_accumulator_core
// sample covariance matrix of a centred data stream, emitted entry by entry
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_data): one sample per
//   transfer, row-major; last_of_set marks the final sample of the set.
//   while the input is not stalled, samples stream in one per cycle into a
//   chain of MAX_COLUMNS cells, each cell multiplying its stored row sample
//   by the passing sample and adding into its own row of sums; a sample
//   leaves the chain after passing the token register of every cell.
//   on the last sample the input stalls, the chain drains, then cols*cols
//   entries go out (o_out_valid / i_out_stall / o_out_data) in row-major
//   order. an entry of a set with fewer than two rows skips the divider;
//   otherwise each entry waits on the bit-serial divider (49 steps).
//   a stalled entry holds until taken. after the last entry the sums and
//   counters clear and the input opens again.
//   configuration (i_cfg_valid / o_cfg_ready / i_cfg_data) sets the column
//   count and restarts the set; it is taken only while no set is unloading,
//   the chain is empty and no sample is offered.
//   reset: synchronous, active low; sums and counters clear at once, column
//   count returns to 8.
// ----------------------------------------------------------------------------
module covariance_matrix_accumulator_core #(
    parameter int MAX_ROWS = cmac_pkg::MAX_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  cmac_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output cmac_pkg::t_out              o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cmac_pkg::CFG_W-1:0]  i_cfg_data
);
    import cmac_pkg::*;

    localparam int ROW_W = $clog2(MAX_ROWS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_READ,
        S_DIV,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [CFG_W-1:0]        r_cols_raw;
    logic [COL_W-1:0]        r_col_pos;
    logic [ROW_W-1:0]        r_row_cnt;
    logic [COL_W-1:0]        r_i;
    logic [COL_W-1:0]        r_j;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_too_few;
    t_out                    r_out;
    logic                    r_out_valid;

    logic [CFG_W-1:0]        w_cols;
    logic [COL_W-1:0]        w_col;
    logic                    w_in_xfer;
    logic                    w_cfg_xfer;
    logic                    w_out_xfer;
    logic                    w_clear;
    logic                    w_is_last;
    logic                    w_chain_busy;
    logic [COL_W-1:0]        w_rd_col;
    logic [COL_W-1:0]        w_rd_row;
    logic [SUM_W-1:0]        w_mag;
    logic [ROW_W-1:0]        w_den;
    logic [DIVD_W-1:0]       w_num;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [DIVD_W-1:0]       w_quo;
    logic [COV_W-1:0]        w_cov;

    t_tok                    w_tok [MAX_COLUMNS+1];
    logic [SUM_W-1:0]        w_rd [MAX_COLUMNS];

    // effective column count, clamped to 2..MAX_COLUMNS
    always_comb begin
        if (r_cols_raw < COLS_MIN) begin
            w_cols = COLS_MIN;
        end else if (r_cols_raw > COLS_MAX) begin
            w_cols = COLS_MAX;
        end else begin
            w_cols = r_cols_raw;
        end
    end

    // any sample still travelling through the cells
    always_comb begin
        w_chain_busy = 1'b0;
        for (int k = 1; k <= MAX_COLUMNS; k++) begin
            w_chain_busy = w_chain_busy | w_tok[k].valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !w_chain_busy && !i_in_valid;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;
    assign w_out_xfer  = r_out_valid && !i_out_stall;
    assign w_clear     = w_cfg_xfer || (w_out_xfer && r_out.last_entry);

    // wraps to zero if the position ever sits at or past the column count
    assign w_col = ({1'b0, r_col_pos} >= w_cols) ? '0 : r_col_pos;

    assign w_tok[0].valid = w_in_xfer;
    assign w_tok[0].last  = i_in_data.last_of_set;
    assign w_tok[0].col   = w_col;
    assign w_tok[0].x     = i_in_data.sample;

    // upper triangle: cell = smaller index, entry = larger index
    assign w_rd_row = (r_i <= r_j) ? r_i : r_j;
    assign w_rd_col = (r_i <= r_j) ? r_j : r_i;

    for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cell
        cmac_cell #(
            .CELL_IDX (COL_W'(g))
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (w_clear),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1]),
            .i_rd_col  (w_rd_col),
            .o_rd_data (w_rd[g])
        );
    end

    // rounded division: (|sum| + d/2) / d
    assign w_den       = r_row_cnt - 1'b1;
    assign w_mag       = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_num       = {1'b0, w_mag} + DIVD_W'(w_den >> 1);
    assign w_div_start = (r_state == S_DIV) && !r_too_few;

    cmac_div #(
        .ROW_W (ROW_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // saturate the signed quotient to 32 bits
    always_comb begin
        if (r_sum[SUM_W-1]) begin
            if (w_quo > DIVD_W'(33'h0_8000_0000)) begin
                w_cov = {1'b1, {(COV_W-1){1'b0}}};
            end else begin
                w_cov = -w_quo[COV_W-1:0];
            end
        end else begin
            if (w_quo > DIVD_W'(32'h7FFF_FFFF)) begin
                w_cov = {1'b0, {(COV_W-1){1'b1}}};
            end else begin
                w_cov = w_quo[COV_W-1:0];
            end
        end
    end

    assign w_is_last = ({1'b0, r_i} == w_cols - 1'b1) && ({1'b0, r_j} == w_cols - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cols_raw  <= COLS_RESET;
            r_col_pos   <= '0;
            r_row_cnt   <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_cfg_xfer) begin
                        r_cols_raw <= i_cfg_data;
                        r_col_pos  <= '0;
                        r_row_cnt  <= '0;
                    end else if (w_in_xfer) begin
                        // row complete: count it, saturating
                        if ({1'b0, w_col} + 1'b1 >= w_cols) begin
                            r_col_pos <= '0;
                            if (r_row_cnt < ROW_W'(MAX_ROWS)) begin
                                r_row_cnt <= r_row_cnt + 1'b1;
                            end
                        end else begin
                            r_col_pos <= w_col + 1'b1;
                        end
                        if (i_in_data.last_of_set) begin
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    // last sample has left the chain, all sums settled
                    if (w_tok[MAX_COLUMNS].valid && w_tok[MAX_COLUMNS].last) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_sum     <= w_rd[w_rd_row];
                    r_too_few <= (r_row_cnt < ROW_W'(2));
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    if (r_too_few) begin
                        r_out.row_index    <= r_i;
                        r_out.col_index    <= r_j;
                        r_out.covariance   <= '0;
                        r_out.too_few_rows <= 1'b1;
                        r_out.last_entry   <= w_is_last;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_OUT;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_div_done) begin
                        r_out.row_index    <= r_i;
                        r_out.col_index    <= r_j;
                        r_out.covariance   <= w_cov;
                        r_out.too_few_rows <= 1'b0;
                        r_out.last_entry   <= w_is_last;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_xfer) begin
                        r_out_valid <= 1'b0;
                        if (r_out.last_entry) begin
                            r_col_pos <= '0;
                            r_row_cnt <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            if ({1'b0, r_j} + 1'b1 >= w_cols) begin
                                r_j <= '0;
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // row count never passes its ceiling
    a_row_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_cnt <= ROW_W'(MAX_ROWS))
        else $error("row count above ceiling");

    // column position stays inside the matrix
    a_col_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col_pos} < w_cols)
        else $error("column position out of range");

    // final entry taken returns the block to accepting samples
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && r_out.last_entry) |=> (r_state == S_IDLE) && !o_in_stall)
        else $error("block not idle after last entry");

    // flagged entries carry a zero value
    a_too_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.too_few_rows) |-> (o_out_data.covariance == '0))
        else $error("too_few_rows entry with nonzero value");

endmodule
